// ===== rtl/smft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smft_pkg
// Shared constants, result codes and controller/datapath handshake types
// for the sorted multiset floor-take unit.
// ----------------------------------------------------------------------------
package smft_pkg;

   // default number of entries the store can hold
   localparam int SMFT_CAPACITY = 64;

   // item actions
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_TAKEN    = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic load_item;     // capture item, start search window
      logic search_issue;  // read the midpoint entry
      logic search_cmp;    // narrow the window with the read entry
      logic note_result;   // latch the status of this item
      logic shift_init;    // set the shift pointer
      logic shift_rd;      // read the neighbor of the shift pointer
      logic shift_wr;      // move that neighbor into the pointer slot
      logic put;           // write the inserted value, bump count
      logic del_finish;    // drop the count after a take
      logic load_rsp;      // load the output register
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_query;
      logic full;
      logic search_done;
      logic found;
      logic shift_done;
      logic rsp_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/smft_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smft_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface smft_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface smft_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] taken_value;

   modport source (output valid, output status, output taken_value, input ready);
   modport sink   (input valid, input status, input taken_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/smft_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smft_ctrl
// Sequencer: binary search over the store, then an entry-by-entry shift (read,
// then write) to open or close a gap, then result hand-off.
// ----------------------------------------------------------------------------
module smft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  smft_pkg::dp_stat_type stat,
   output smft_pkg::dp_cmd_type  cmd
);
   import smft_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_SRCH_ADDR = 7'b0000010,
      S_SRCH_CMP  = 7'b0000100,
      S_SHF_RD    = 7'b0001000,
      S_SHF_WR    = 7'b0010000,
      S_PUT       = 7'b0100000,
      S_FINISH    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SRCH_ADDR;
            end
         end
         S_SRCH_ADDR: begin
            priority if (!stat.is_query && stat.full) begin
               cmd.note_result = 1'b1;
               state_in        = S_FINISH;
            end else if (stat.search_done) begin
               cmd.note_result = 1'b1;
               if (stat.is_query && !stat.found) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHF_RD;
               end
            end else begin
               cmd.search_issue = 1'b1;
               state_in         = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.search_cmp = 1'b1;
            state_in       = S_SRCH_ADDR;
         end
         S_SHF_RD: begin
            if (stat.shift_done) begin
               if (stat.is_query) begin
                  cmd.del_finish = 1'b1;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHF_WR;
            end
         end
         S_SHF_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHF_RD;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/smft_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smft_datapath
// Entry memory, search window, shift pointer, item and result registers.
// ----------------------------------------------------------------------------
module smft_datapath #(
   parameter int CAPACITY = smft_pkg::SMFT_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smft_pkg::dp_cmd_type  cmd,
   output smft_pkg::dp_stat_type stat,
   input  logic                 req_action,
   input  logic [31:0]          req_value,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_taken_value
);
   import smft_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // entry memory, ascending in slots 0 .. count-1
   logic [31:0]   entry_store [CAPACITY];
   logic [31:0]   rd_data_ff;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   wr_data;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          action_ff, action_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   taken_ff, taken_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_taken_ff, rsp_taken_in;

   logic [CW:0]   mid_sum;
   logic [CW-1:0] lo_m1;
   logic [CW-1:0] ptr_p1;
   logic          is_query;
   logic          full;
   logic          found;

   assign is_query = (action_ff == ACT_QUERY);
   assign full     = (count_ff == CW'(CAPACITY));
   assign found    = (lo_ff != '0);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign lo_m1    = lo_ff - CW'(1);
   assign ptr_p1   = CW'(ptr_ff) + CW'(1);

   // status to controller
   always_comb begin
      stat.is_query    = is_query;
      stat.full        = full;
      stat.search_done = (lo_ff >= hi_ff);
      stat.found       = found;
      stat.shift_done  = is_query ? (ptr_p1 == count_ff) : (CW'(ptr_ff) == lo_ff);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory port control
   always_comb begin
      mem_we  = cmd.shift_wr || cmd.put;
      mem_re  = cmd.search_issue || cmd.shift_rd;
      wr_addr = cmd.put ? lo_ff[AW-1:0] : ptr_ff;
      wr_data = cmd.put ? value_ff : rd_data_ff;
      if (cmd.shift_rd) begin
         rd_addr = is_query ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
      end else begin
         rd_addr = mid_in[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= entry_store[rd_addr];
      end
   end

   // search window, shift pointer and item registers
   always_comb begin
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_sum[CW:1];
      ptr_in    = ptr_ff;
      action_in = action_ff;
      value_in  = value_ff;
      taken_in  = taken_ff;
      status_in = status_ff;
      if (cmd.load_item) begin
         action_in = req_action;
         value_in  = req_value;
         lo_in     = '0;
         hi_in     = count_ff;
      end
      if (cmd.search_cmp) begin
         if (rd_data_ff <= value_ff) begin
            lo_in    = mid_ff + CW'(1);
            taken_in = rd_data_ff;
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.note_result) begin
         if (is_query) begin
            status_in = found ? ST_TAKEN : ST_NONE;
         end else begin
            status_in = full ? ST_DROPPED : ST_INSERTED;
         end
      end
      if (cmd.shift_init) begin
         ptr_in = is_query ? lo_m1[AW-1:0] : count_ff[AW-1:0];
      end
      if (cmd.shift_wr) begin
         ptr_in = is_query ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
      end
      if (cmd.put) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.del_finish) begin
         count_in = count_ff - CW'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_taken_in  = rsp_taken_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_taken_in  = (status_ff == ST_TAKEN) ? taken_ff : 32'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ptr_ff        <= ptr_in;
      action_ff     <= action_in;
      value_ff      <= value_in;
      taken_ff      <= taken_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_taken_ff  <= rsp_taken_in;
      if (cmd.search_issue) begin
         mid_ff <= mid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_taken_value = rsp_taken_ff;

endmodule
`default_nettype wire

// ===== rtl/sorted_multiset_floor_take_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a dropped insert skips the search and the shift; a query that finds nothing
//   skips the shift; a take or an insert searches, then shifts the entries for the
//   gap, and an insert then writes its value.
// Throughput: one item at a time; the next request transfer is taken once the result
//   is in the output register, even while that result waits on the sink.
// Reset: synchronous active high; empties the store (count cleared), no memory sweep.
// ----------------------------------------------------------------------------
// sorted_multiset_floor_take_unit
// Ordered multiset with insert and floor-take (remove largest value <= limit).
// ----------------------------------------------------------------------------
module sorted_multiset_floor_take_unit #(
   parameter int CAPACITY = smft_pkg::SMFT_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   smft_req_if.sink   req_ch,
   smft_rsp_if.source rsp_ch
);
   import smft_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   smft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store and result datapath
   smft_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_ch.action),
      .req_value       (req_ch.value),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_taken_value (rsp_ch.taken_value)
   );

   // a request transfer always starts the sequencer
   a_req_loads: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> cmd.load_item)
      else $error("request transfer without item load");

   // the output register is never overwritten while a result is pending
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result loaded over a pending result");

   // only a taken query carries a value
   a_taken_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != ST_TAKEN)) |-> (rsp_ch.taken_value == 32'd0))
      else $error("nonzero taken value on a result that took nothing");

   // a new item only loads after the previous result was handed to the output
   a_load_after_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> req_ch.ready)
      else $error("sequencer not ready after result load");

endmodule
`default_nettype wire

// ===== tb/sv/tb_sorted_multiset_floor_take_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_multiset_floor_take_unit
// Self-checking bench for the ordered multiset with insert and floor-take.
// A short scripted opening covers the empty store, the extreme values,
// duplicates and the all-above and all-below limit cases. Random traffic
// follows, swinging between filling the store past capacity and draining it
// to empty, under several idle and stall mixes. Every result transfer is
// compared field by field with its script row or a local sorted-array model.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_floor_take_unit;
   import smft_pkg::*;

   localparam int DEPTH         = SMFT_CAPACITY;
   localparam int PHASE_ITEMS   = 470;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] taken;
   } ticket_result_type;

   // one scripted item; typed marks rows whose result is written out here
   typedef struct packed {
      logic        action;
      logic [31:0] value;
      logic        typed;
      logic [1:0]  status;
      logic [31:0] taken;
   } script_row_type;

   localparam int SCRIPT_LEN = 19;
   localparam script_row_type OPENING [0:SCRIPT_LEN-1] = '{
      '{ACT_QUERY,  32'h0000_0000, 1'b1, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, ST_NONE,     32'h0000_0000},
      '{ACT_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'h0000_0064, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'h0000_0064, 1'b1, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'h8000_0000, 1'b0, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'h5555_5555, 1'b0, ST_INSERTED, 32'h0000_0000},
      '{ACT_INSERT, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, 32'h0000_0000},
      '{ACT_QUERY,  32'h0000_0063, 1'b1, ST_TAKEN,    32'h0000_0000},
      '{ACT_QUERY,  32'h0000_0063, 1'b1, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, ST_TAKEN,    32'hFFFF_FFFF},
      '{ACT_QUERY,  32'hAAAA_AAA9, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'h0000_0064, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'h0000_0064, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'h0000_0064, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'hFFFF_FFFE, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'h5555_5555, 1'b0, ST_NONE,     32'h0000_0000},
      '{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, ST_NONE,     32'h0000_0000}
   };

   logic clock;
   logic reset;

   smft_req_if req_ch ();
   smft_rsp_if rsp_ch ();

   sorted_multiset_floor_take_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // local copy of the store, ascending
   logic [31:0] price_book [DEPTH];
   int          book_count = 0;

   ticket_result_type pending_results [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int sender_idle   = 0;
   int stall_pct     = 0;
   int hold_req      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // apply one item to the local store and return its result
   function automatic ticket_result_type floor_take_predict(logic act, logic [31:0] val);
      ticket_result_type r;
      int                k;
      int                i;
      r.status = ST_NONE;
      r.taken  = 32'h0;
      k = 0;
      while (k < book_count && price_book[k] <= val)
         k++;
      if (act == ACT_INSERT) begin
         if (book_count >= DEPTH) begin
            r.status = ST_DROPPED;
         end else begin
            for (i = book_count; i > k; i--)
               price_book[i] = price_book[i-1];
            price_book[k] = val;
            book_count++;
            r.status = ST_INSERTED;
         end
      end else if (k > 0) begin
         r.taken = price_book[k-1];
         for (i = k - 1; i < book_count - 1; i++)
            price_book[i] = price_book[i+1];
         book_count--;
         r.status = ST_TAKEN;
      end
      return r;
   endfunction

   // random value, biased toward duplicates, extremes and stored entries
   function automatic logic [31:0] pick_value(logic act);
      int roll;
      int offset;
      roll = $urandom_range(99);
      if (act == ACT_QUERY && book_count > 0 && roll < 35) begin
         offset = $urandom_range(2);
         return price_book[$urandom_range(book_count - 1)] + 32'(offset) - 32'd1;
      end
      if (roll < 55)
         return 32'($urandom_range(15));
      if (roll < 65) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // offer one item, hold it until the transfer, then log its expected result
   task automatic offer_item(input logic act, input logic [31:0] val,
                             input logic typed, input ticket_result_type typed_res);
      ticket_result_type res;
      while ($urandom_range(99) < sender_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
      res = floor_take_predict(act, val);
      if (typed)
         res = typed_res;
      pending_results.push_back(res);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // result side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      ticket_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: status %0d taken %h",
                        rsp_ch.status, rsp_ch.taken_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.taken_value !== want.taken) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: status exp %0d got %0d, taken exp %h got %h",
                           want.status, rsp_ch.status, want.taken, rsp_ch.taken_value);
            end
         end
      end
      if (hold_req != hold_seen) begin
         hold_seen    <= hold_req;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // stimulus
   initial begin
      int                phase;
      int                n;
      int                full_tries;
      int                empty_tries;
      bit                filling;
      logic              act;
      ticket_result_type fixed_res;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_INSERT;
      req_ch.value  = 32'h0;
      full_tries    = 0;
      empty_tries   = 0;
      filling       = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // scripted opening
      for (n = 0; n < SCRIPT_LEN; n++) begin
         fixed_res.status = OPENING[n].status;
         fixed_res.taken  = OPENING[n].taken;
         offer_item(OPENING[n].action, OPENING[n].value, OPENING[n].typed, fixed_res);
      end

      // random traffic under four idle/stall mixes
      fixed_res = '0;
      for (phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0: begin sender_idle = 0;  stall_pct <= 0;  end
            1: begin sender_idle = 86; stall_pct <= 0;  end
            2: begin sender_idle = 0;  stall_pct <= 86; end
            default: begin sender_idle = 22; stall_pct <= 22; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // long result hold while items keep coming, to back up the input
            if (phase == 0 && n == 100)
               hold_req <= hold_req + 1;
            // swing between filling past capacity and draining to empty
            if (filling && book_count == DEPTH)
               full_tries++;
            if (!filling && book_count == 0)
               empty_tries++;
            if (full_tries >= 5 || (filling && $urandom_range(99) < 1)) begin
               filling    = 1'b0;
               full_tries = 0;
            end else if (empty_tries >= 4 || (!filling && $urandom_range(99) < 1)) begin
               filling     = 1'b1;
               empty_tries = 0;
            end
            if ($urandom_range(99) < 82)
               act = filling ? ACT_INSERT : ACT_QUERY;
            else
               act = filling ? ACT_QUERY : ACT_INSERT;
            offer_item(act, pick_value(act), 1'b0, fixed_res);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
